[hw/rtl/tpms_pkg.sv]
// shared constants and types of the triangle minimum path sum block
package tpms_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;

    localparam int VAL_W  = 16;
    localparam int SUM_W  = 22;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int RIDX_W = $clog2(MAX_ROWS);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SEED,
        S_FOLD,
        S_DONE
    } t_state;

endpackage

[hw/rtl/triangle_min_path_sum_top.sv]
// triangle minimum path sum: element loader, row buffer and bottom-up fold sequencer
//
// input channel (i_valid / o_ready): one signed 16-bit element per word, rows from the
// top, row r holding r+1 elements; i_last_item marks the final word of a triangle.
// elements are taken one per cycle while loading.
// output channel (o_valid / i_ready): one word per triangle with the minimum path sum,
// the row count and an error flag; on error (element count not triangular, or more
// than 2080 elements) sum and row count are zero.
// after the last word the block stops taking words and runs the fold through one
// adder and compare: the last row is copied into the row buffer, then each upper
// row r (r = n-2 down to 0, for n rows) is folded one element per cycle, limited by
// the single read port of the element memory and of the row buffer. the result sits
// in an output register; loading of the next triangle starts while it waits, and a
// finished fold waits until the register frees.
// reset (synchronous, active low) empties the load state and the output register;
// the memories are not cleared and are read only where written in the same load.
module triangle_min_path_sum_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [tpms_pkg::VAL_W-1:0]     i_value,
    input  logic                                  i_last_item,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [tpms_pkg::SUM_W-1:0]     o_min_sum,
    output logic        [tpms_pkg::ROW_W-1:0]     o_row_count,
    output logic                                  o_error
);

    localparam int VAL_W  = tpms_pkg::VAL_W;
    localparam int SUM_W  = tpms_pkg::SUM_W;
    localparam int CNT_W  = tpms_pkg::CNT_W;
    localparam int ADDR_W = tpms_pkg::ADDR_W;
    localparam int ROW_W  = tpms_pkg::ROW_W;
    localparam int RIDX_W = tpms_pkg::RIDX_W;

    tpms_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]         r_count, n_count;
    logic [ROW_W-1:0]         r_row, n_row;
    logic [RIDX_W-1:0]        r_col, n_col;
    logic [ADDR_W-1:0]        r_row_start, n_row_start;
    logic                     r_ovf, n_ovf;
    logic [ROW_W-1:0]         r_rows, n_rows;
    logic [ADDR_W-1:0]        r_base, n_base;
    logic [RIDX_W-1:0]        r_frow, n_frow;
    logic [ROW_W-1:0]         r_j, n_j;
    logic signed [SUM_W-1:0]  r_left, n_left;
    logic signed [SUM_W-1:0]  r_pend_sum, n_pend_sum;
    logic [ROW_W-1:0]         r_pend_rows, n_pend_rows;
    logic                     r_pend_err, n_pend_err;
    logic                     r_out_valid, n_out_valid;
    logic signed [SUM_W-1:0]  r_out_sum, n_out_sum;
    logic [ROW_W-1:0]         r_out_rows, n_out_rows;
    logic                     r_out_err, n_out_err;

    // element memory
    logic signed [VAL_W-1:0]  elem_mem [tpms_pkg::STORE_DEPTH];
    logic                     elem_we;
    logic [ADDR_W-1:0]        elem_waddr;
    logic [ADDR_W-1:0]        elem_raddr;
    logic signed [VAL_W-1:0]  r_elem_rdata;

    // row buffer
    logic signed [SUM_W-1:0]  rs_mem [tpms_pkg::MAX_ROWS];
    logic                     rs_we;
    logic [RIDX_W-1:0]        rs_waddr;
    logic signed [SUM_W-1:0]  rs_wdata;
    logic [RIDX_W-1:0]        rs_raddr;
    logic signed [SUM_W-1:0]  r_rs_rdata;

    logic signed [SUM_W-1:0]  elem_ext;
    logic signed [SUM_W-1:0]  below;
    logic signed [SUM_W-1:0]  fold_sum;
    logic                     full;
    logic                     row_done;
    logic [ROW_W-1:0]         last_j;

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= i_value;
        end
        r_elem_rdata <= elem_mem[elem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        r_rs_rdata <= rs_mem[rs_raddr];
    end

    assign elem_ext = {{(SUM_W - VAL_W){r_elem_rdata[VAL_W-1]}}, r_elem_rdata};
    assign below    = (r_left < r_rs_rdata) ? r_left : r_rs_rdata;
    assign fold_sum = elem_ext + below;
    assign full     = (r_count == CNT_W'(tpms_pkg::STORE_DEPTH));
    assign row_done = !full && (r_col == r_row[RIDX_W-1:0]);
    assign last_j   = ROW_W'(r_frow) + ROW_W'(2);

    assign o_ready     = (r_state == tpms_pkg::S_LOAD);
    assign o_valid     = r_out_valid;
    assign o_min_sum   = r_out_sum;
    assign o_row_count = r_out_rows;
    assign o_error     = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpms_pkg::S_LOAD;
            r_count     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_row_start <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_start <= n_row_start;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows      <= n_rows;
        r_base      <= n_base;
        r_frow      <= n_frow;
        r_j         <= n_j;
        r_left      <= n_left;
        r_pend_sum  <= n_pend_sum;
        r_pend_rows <= n_pend_rows;
        r_pend_err  <= n_pend_err;
        r_out_sum   <= n_out_sum;
        r_out_rows  <= n_out_rows;
        r_out_err   <= n_out_err;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_row       = r_row;
        n_col       = r_col;
        n_row_start = r_row_start;
        n_ovf       = r_ovf;
        n_rows      = r_rows;
        n_base      = r_base;
        n_frow      = r_frow;
        n_j         = r_j;
        n_left      = r_left;
        n_pend_sum  = r_pend_sum;
        n_pend_rows = r_pend_rows;
        n_pend_err  = r_pend_err;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_rows  = r_out_rows;
        n_out_err   = r_out_err;
        elem_we     = 1'b0;
        elem_waddr  = r_count[ADDR_W-1:0];
        elem_raddr  = '0;
        rs_we       = 1'b0;
        rs_waddr    = '0;
        rs_wdata    = fold_sum;
        rs_raddr    = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tpms_pkg::S_LOAD: begin
                if (i_valid) begin
                    if (!full) begin
                        elem_we = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        if (row_done) begin
                            n_row       = r_row + ROW_W'(1);
                            n_col       = '0;
                            n_row_start = ADDR_W'(r_count + CNT_W'(1));
                        end else begin
                            n_col = r_col + RIDX_W'(1);
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_count     = '0;
                        n_row       = '0;
                        n_col       = '0;
                        n_row_start = '0;
                        n_ovf       = 1'b0;
                        if (row_done && !r_ovf) begin
                            n_rows  = r_row + ROW_W'(1);
                            n_base  = r_row_start;
                            n_j     = '0;
                            n_state = tpms_pkg::S_SEED;
                        end else begin
                            n_pend_sum  = '0;
                            n_pend_rows = '0;
                            n_pend_err  = 1'b1;
                            n_state     = tpms_pkg::S_DONE;
                        end
                    end
                end
            end
            tpms_pkg::S_SEED: begin
                // copy the bottom row into the row buffer
                if (r_j < r_rows) begin
                    elem_raddr = r_base + ADDR_W'(r_j);
                end
                if (r_j != '0) begin
                    rs_we    = 1'b1;
                    rs_waddr = RIDX_W'(r_j - ROW_W'(1));
                    rs_wdata = elem_ext;
                end
                if (r_j == r_rows) begin
                    if (r_rows == ROW_W'(1)) begin
                        n_pend_sum  = elem_ext;
                        n_pend_rows = r_rows;
                        n_pend_err  = 1'b0;
                        n_state     = tpms_pkg::S_DONE;
                    end else begin
                        n_frow  = RIDX_W'(r_rows - ROW_W'(2));
                        n_base  = r_base - ADDR_W'(r_rows - ROW_W'(1));
                        n_j     = '0;
                        n_state = tpms_pkg::S_FOLD;
                    end
                end else begin
                    n_j = r_j + ROW_W'(1);
                end
            end
            tpms_pkg::S_FOLD: begin
                // step j reads buffer entry j and element j-1, writes entry j-2
                if (r_j <= ROW_W'(r_frow) + ROW_W'(1)) begin
                    rs_raddr = RIDX_W'(r_j);
                    if (r_j != '0) begin
                        elem_raddr = r_base + ADDR_W'(r_j) - ADDR_W'(1);
                    end
                end
                if (r_j == ROW_W'(1)) begin
                    n_left = r_rs_rdata;
                end
                if (r_j >= ROW_W'(2)) begin
                    rs_we    = 1'b1;
                    rs_waddr = RIDX_W'(r_j - ROW_W'(2));
                    rs_wdata = fold_sum;
                    n_left   = r_rs_rdata;
                end
                if (r_j == last_j) begin
                    if (r_frow == '0) begin
                        n_pend_sum  = fold_sum;
                        n_pend_rows = r_rows;
                        n_pend_err  = 1'b0;
                        n_state     = tpms_pkg::S_DONE;
                    end else begin
                        n_frow = r_frow - RIDX_W'(1);
                        n_base = r_base - ADDR_W'(r_frow);
                        n_j    = '0;
                    end
                end else begin
                    n_j = r_j + ROW_W'(1);
                end
            end
            tpms_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_pend_sum;
                    n_out_rows  = r_pend_rows;
                    n_out_err   = r_pend_err;
                    n_state     = tpms_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = tpms_pkg::S_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(tpms_pkg::STORE_DEPTH))
        else $error("element count beyond store depth");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_item) |=> (r_count == '0 && !r_ovf))
        else $error("load state not cleared after last word");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_min_sum == '0 && o_row_count == '0))
        else $error("error result carries nonzero fields");

    a_rows_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_error) |->
            (o_row_count != '0 && o_row_count <= ROW_W'(tpms_pkg::MAX_ROWS)))
        else $error("row count out of range");

    a_fold_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tpms_pkg::S_FOLD) |-> (r_j <= last_j && r_frow < RIDX_W'(r_rows - ROW_W'(1))))
        else $error("fold step counter out of range");
`endif

endmodule
